// File: hdl/nmat_pkg.sv
`timescale 1ns / 1ps
// Shared constants, field widths and result action codes for the marker table.
// No dependencies; imported by the table unit and its checker.
package nmat_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int POS_BITS_DEF    = 24;

  localparam int GATE_W      = 52;
  localparam int ID_W        = 10;
  localparam int QUAT_W      = 16;
  localparam int LABEL_W     = 32;
  localparam int SLOT_PORT_W = 6;
  localparam int ACT_W       = 3;

  localparam logic [GATE_W-1:0]  GATE_RESET  = GATE_W'(4194304);
  localparam logic [LABEL_W-1:0] LABEL_FIRST = LABEL_W'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_UPDATED    = 3'd0,
    ACT_ADDED      = 3'd1,
    ACT_DROPPED    = 3'd2,
    ACT_READ_VALID = 3'd3,
    ACT_READ_EMPTY = 3'd4
  } action_e;

endpackage

// File: hdl/nearest_marker_association_table_unit.sv
`timescale 1ns / 1ps
// Nearest-marker association table: gated nearest-neighbor match against a
// table of marker poses, with append and slot read. Depends on nmat_pkg.
//
//  channel  | handshake                       | word
//  ---------+---------------------------------+-------------------------------
//  command  | start_i, busy_o (take: start&!busy) | opcode, read_slot, marker_id,
//           |                                 | pos_x/y/z, quat_x/y/z/w
//  result   | done_o (one-cycle strobe)       | slot, action, label, entry_*
//  config   | cfg_valid_i, cfg_ready_o        | cfg_wdata_i (gate, squared)
//
// A detection scans every valid entry through the single squaring multiplier,
// which handles one axis of one entry per cycle; an empty table skips the scan
// and a drop skips the write. A read of a valid slot fetches its three position
// words through one memory port; a read of an empty slot returns in the cycle
// after it is taken.
// Reset empties the table count, sets the label counter to one and the gate to
// its default of (2 m)^2; the table memories are not cleared since only slots
// below the count are ever read.
// The result strobe cannot be stalled; a new command is taken in the cycle
// that shows a result.
module nearest_marker_association_table_unit
  import nmat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int POS_BITS    = POS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command word
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       opcode_i,
  input  logic [SLOT_PORT_W-1:0]     read_slot_i,
  input  logic [ID_W-1:0]            marker_id_i,
  input  logic signed [POS_BITS-1:0] pos_x_i,
  input  logic signed [POS_BITS-1:0] pos_y_i,
  input  logic signed [POS_BITS-1:0] pos_z_i,
  input  logic signed [QUAT_W-1:0]   quat_x_i,
  input  logic signed [QUAT_W-1:0]   quat_y_i,
  input  logic signed [QUAT_W-1:0]   quat_z_i,
  input  logic signed [QUAT_W-1:0]   quat_w_i,
  // result word
  output logic                       done_o,
  output logic [SLOT_PORT_W-1:0]     slot_o,
  output logic [ACT_W-1:0]           action_o,
  output logic [LABEL_W-1:0]         label_o,
  output logic [ID_W-1:0]            entry_id_o,
  output logic signed [POS_BITS-1:0] entry_x_o,
  output logic signed [POS_BITS-1:0] entry_y_o,
  output logic signed [POS_BITS-1:0] entry_z_o,
  output logic signed [QUAT_W-1:0]   entry_qx_o,
  output logic signed [QUAT_W-1:0]   entry_qy_o,
  output logic signed [QUAT_W-1:0]   entry_qz_o,
  output logic signed [QUAT_W-1:0]   entry_qw_o,
  // configuration word
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [GATE_W-1:0]          cfg_wdata_i
);

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int PADDR_W = $clog2(TABLE_DEPTH * 3);
  localparam int DIFF_W  = POS_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int CMP_W   = (SUM_W > GATE_W) ? SUM_W : GATE_W;
  localparam int RC_W    = (SLOT_PORT_W > CNT_W) ? SLOT_PORT_W : CNT_W;
  localparam int ROT_W   = 4 * QUAT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] AX_DONE = 2'd3;

  // table memories
  logic signed [POS_BITS-1:0] pos_mem [TABLE_DEPTH*3];
  logic [ID_W-1:0]            id_mem  [TABLE_DEPTH];
  logic [ROT_W-1:0]           rot_mem [TABLE_DEPTH];
  logic [LABEL_W-1:0]         lab_mem [TABLE_DEPTH];

  logic signed [POS_BITS-1:0] pos_rd_q;
  logic [ID_W-1:0]            id_rd_q;
  logic [ROT_W-1:0]           rot_rd_q;
  logic [LABEL_W-1:0]         lab_rd_q;

  // control state
  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [LABEL_W-1:0]  next_label_q;
  logic [GATE_W-1:0]   gate_q;
  logic                done_q;
  logic                s1_vld_q, s2_vld_q;
  logic                found_q;

  // sequencer and latched command
  logic [SLOT_W-1:0]          cur_slot_q;
  logic [PADDR_W-1:0]         pos_addr_q;
  logic [1:0]                 k_q;
  logic                       add_q;
  logic                       op_q;
  logic [ID_W-1:0]            id_q;
  logic signed [POS_BITS-1:0] det_x_q, det_y_q, det_z_q;
  logic [ROT_W-1:0]           det_rot_q;

  // distance pipeline
  logic [1:0]        s1_k_q, s2_k_q;
  logic [SLOT_W-1:0] s1_slot_q, s2_slot_q;
  logic              s2_match_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SUM_W-1:0]  acc_q;
  logic [SUM_W-1:0]  best_q;
  logic [SLOT_W-1:0] best_slot_q;

  // result word
  logic [SLOT_PORT_W-1:0]     out_slot_q;
  logic [ACT_W-1:0]           out_act_q;
  logic [LABEL_W-1:0]         out_label_q;
  logic [ID_W-1:0]            out_id_q;
  logic signed [POS_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [ROT_W-1:0]           out_rot_q;

  logic                       accept;
  logic                       rd_ok;
  logic                       hit;
  logic                       full;
  logic                       last_issue;
  logic [SLOT_W-1:0]          rd_slot;
  logic signed [POS_BITS-1:0] sel_det;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SQ_W-1:0]     prod;
  logic [SUM_W-1:0]           total;
  logic signed [POS_BITS-1:0] wr_pos;

  function automatic logic op_is_read(input logic op);
    return op;
  endfunction

  assign accept      = start_i && (state_q == ST_IDLE);
  assign rd_slot     = SLOT_W'(read_slot_i);
  assign rd_ok       = RC_W'(read_slot_i) < RC_W'(cnt_q);
  assign hit         = found_q && (CMP_W'(best_q) < CMP_W'(gate_q));
  assign full        = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign last_issue  = (k_q == AX_Z) && ((CNT_W'(cur_slot_q) + CNT_W'(1)) == cnt_q);
  assign total       = acc_q + SUM_W'(sq_q);

  // Pick the detected axis that matches the word coming out of the memory.
  always_comb begin
    case (s1_k_q)
      AX_X:    sel_det = det_x_q;
      AX_Y:    sel_det = det_y_q;
      AX_Z:    sel_det = det_z_q;
      default: sel_det = '0;
    endcase
  end

  // Shared squaring unit: one axis difference squared per cycle.
  assign diff = DIFF_W'(sel_det) - DIFF_W'(pos_rd_q);
  assign prod = diff * diff;

  always_comb begin
    case (k_q)
      AX_X:    wr_pos = det_x_q;
      AX_Y:    wr_pos = det_y_q;
      AX_Z:    wr_pos = det_z_q;
      default: wr_pos = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_is_read(opcode_i)) begin
            state_d = rd_ok ? ST_READ : ST_IDLE;
          end else begin
            state_d = (cnt_q == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait until the last entry has left the distance pipeline
        if (!s1_vld_q && !s2_vld_q) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = (!hit && full) ? ST_IDLE : ST_WRITE;
      end
      ST_WRITE: begin
        if (k_q == AX_Z) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (k_q == AX_DONE) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      next_label_q <= LABEL_FIRST;
      gate_q       <= GATE_RESET;
      done_q       <= 1'b0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= 1'b0;
      s1_vld_q <= (state_q == ST_SCAN);
      s2_vld_q <= s1_vld_q;
      if (cfg_valid_i) gate_q <= cfg_wdata_i;
      if (accept && !opcode_i) found_q <= 1'b0;
      if (accept && opcode_i && !rd_ok) done_q <= 1'b1;
      // keep the nearest same-id entry; strict compare keeps the lowest slot
      if (s2_vld_q && s2_match_q && (s2_k_q == AX_Z) && (!found_q || total < best_q)) begin
        found_q <= 1'b1;
      end
      case (state_q)
        ST_DECIDE: begin
          if (!hit && full) done_q <= 1'b1;
        end
        ST_WRITE: begin
          if (k_q == AX_Z) begin
            done_q <= 1'b1;
            if (add_q) begin
              cnt_q        <= cnt_q + CNT_W'(1);
              next_label_q <= next_label_q + LABEL_W'(1);
            end
          end
        end
        ST_READ: begin
          if (k_q == AX_DONE) done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[pos_addr_q];
    id_rd_q  <= id_mem[cur_slot_q];
    rot_rd_q <= rot_mem[cur_slot_q];
    lab_rd_q <= lab_mem[cur_slot_q];
    if (state_q == ST_WRITE) begin
      pos_mem[pos_addr_q] <= wr_pos;
      if (k_q == AX_X) begin
        rot_mem[cur_slot_q] <= det_rot_q;
        if (add_q) begin
          id_mem[cur_slot_q]  <= id_q;
          lab_mem[cur_slot_q] <= next_label_q;
        end
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    s1_k_q     <= k_q;
    s1_slot_q  <= cur_slot_q;
    s2_k_q     <= s1_k_q;
    s2_slot_q  <= s1_slot_q;
    s2_match_q <= (id_rd_q == id_q);
    sq_q       <= $unsigned(prod);

    if (s2_vld_q) begin
      case (s2_k_q)
        AX_X:    acc_q <= SUM_W'(sq_q);
        AX_Y:    acc_q <= total;
        default: ;
      endcase
      if (s2_match_q && (s2_k_q == AX_Z) && (!found_q || total < best_q)) begin
        best_q      <= total;
        best_slot_q <= s2_slot_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q      <= opcode_i;
          id_q      <= marker_id_i;
          det_x_q   <= pos_x_i;
          det_y_q   <= pos_y_i;
          det_z_q   <= pos_z_i;
          det_rot_q <= {quat_w_i, quat_z_i, quat_y_i, quat_x_i};
          k_q       <= AX_X;
          if (opcode_i) begin
            cur_slot_q <= rd_slot;
            pos_addr_q <= (PADDR_W'(rd_slot) << 1) + PADDR_W'(rd_slot);
          end else begin
            cur_slot_q <= '0;
            pos_addr_q <= '0;
          end
          // empty slot: answer at once with a blank entry
          out_slot_q  <= read_slot_i;
          out_act_q   <= ACT_READ_EMPTY;
          out_label_q <= '0;
          out_id_q    <= '0;
          out_x_q     <= '0;
          out_y_q     <= '0;
          out_z_q     <= '0;
          out_rot_q   <= '0;
        end
      end
      ST_SCAN: begin
        pos_addr_q <= pos_addr_q + PADDR_W'(1);
        if (k_q == AX_Z) begin
          k_q <= AX_X;
          if (!last_issue) cur_slot_q <= cur_slot_q + SLOT_W'(1);
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
      ST_DECIDE: begin
        k_q <= AX_X;
        if (hit) begin
          add_q      <= 1'b0;
          cur_slot_q <= best_slot_q;
          pos_addr_q <= (PADDR_W'(best_slot_q) << 1) + PADDR_W'(best_slot_q);
        end else if (!full) begin
          add_q      <= 1'b1;
          cur_slot_q <= SLOT_W'(cnt_q);
          pos_addr_q <= (PADDR_W'(cnt_q) << 1) + PADDR_W'(cnt_q);
        end else begin
          out_slot_q  <= '0;
          out_act_q   <= ACT_DROPPED;
          out_label_q <= '0;
          out_id_q    <= '0;
          out_x_q     <= '0;
          out_y_q     <= '0;
          out_z_q     <= '0;
          out_rot_q   <= '0;
        end
      end
      ST_WRITE: begin
        if (k_q != AX_Z) begin
          k_q        <= k_q + 2'd1;
          pos_addr_q <= pos_addr_q + PADDR_W'(1);
        end else begin
          out_slot_q  <= SLOT_PORT_W'(cur_slot_q);
          out_act_q   <= add_q ? ACT_ADDED : ACT_UPDATED;
          out_label_q <= add_q ? next_label_q : lab_rd_q;
          out_id_q    <= id_q;
          out_x_q     <= det_x_q;
          out_y_q     <= det_y_q;
          out_z_q     <= det_z_q;
          out_rot_q   <= det_rot_q;
        end
      end
      ST_READ: begin
        k_q <= k_q + 2'd1;
        if (k_q != AX_Z && k_q != AX_DONE) pos_addr_q <= pos_addr_q + PADDR_W'(1);
        case (k_q)
          AX_Y: out_x_q <= pos_rd_q;
          AX_Z: out_y_q <= pos_rd_q;
          AX_DONE: begin
            out_z_q     <= pos_rd_q;
            out_slot_q  <= SLOT_PORT_W'(cur_slot_q);
            out_act_q   <= op_q ? ACT_READ_VALID : ACT_READ_EMPTY;
            out_label_q <= lab_rd_q;
            out_id_q    <= id_rd_q;
            out_rot_q   <= rot_rd_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign slot_o      = out_slot_q;
  assign action_o    = out_act_q;
  assign label_o     = out_label_q;
  assign entry_id_o  = out_id_q;
  assign entry_x_o   = out_x_q;
  assign entry_y_o   = out_y_q;
  assign entry_z_o   = out_z_q;
  assign entry_qx_o  = out_rot_q[QUAT_W-1:0];
  assign entry_qy_o  = out_rot_q[2*QUAT_W-1:QUAT_W];
  assign entry_qz_o  = out_rot_q[3*QUAT_W-1:2*QUAT_W];
  assign entry_qw_o  = out_rot_q[4*QUAT_W-1:3*QUAT_W];

endmodule

// File: hdl/nmat_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the marker table unit, and the bind that attaches them.
// Depends on nmat_pkg and nearest_marker_association_table_unit.
module nmat_checker
  import nmat_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [SLOT_PORT_W-1:0] slot_o,
  input logic [ACT_W-1:0]       action_o,
  input logic [LABEL_W-1:0]     label_o,
  input logic [ID_W-1:0]        entry_id_o
);

  // every result word carries a defined action
  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (action_o == ACT_UPDATED || action_o == ACT_ADDED ||
                action_o == ACT_DROPPED || action_o == ACT_READ_VALID ||
                action_o == ACT_READ_EMPTY))
    else $error("result word with undefined action");

  // a dropped detection shows a blank entry
  a_drop_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && action_o == ACT_DROPPED) |-> (slot_o == '0 && label_o == '0 &&
                                             entry_id_o == '0))
    else $error("dropped detection shows entry data");

  // an empty read shows no label and no id
  a_empty_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && action_o == ACT_READ_EMPTY) |-> (label_o == '0 && entry_id_o == '0))
    else $error("empty read shows entry data");

  // the unit only turns busy after taking a command word
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a command");

endmodule

bind nearest_marker_association_table_unit nmat_checker u_nmat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .slot_o     (slot_o),
  .action_o   (action_o),
  .label_o    (label_o),
  .entry_id_o (entry_id_o)
);
